// ===== hw/rtl/lsbc_pkg.sv =====
`timescale 1ns / 1ps
package lsbc_pkg;
    localparam int NUM_SLOTS_DEF   = 8;
    localparam int SECTOR_BITS_DEF = 16;
    localparam int SECT_W = 16;
    localparam int SLOT_W = 3;

    localparam logic [1:0] REQ_OBTAIN = 2'd0;
    localparam logic [1:0] REQ_FLAGS  = 2'd1;
    localparam logic [1:0] REQ_FLUSH  = 2'd2;
    localparam logic [1:0] REQ_INVAL  = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // datapath operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LOAD   = 3'd1; // latch request
    localparam logic [2:0] OP_SCAN   = 3'd2; // examine slot at current rank
    localparam logic [2:0] OP_FILL   = 3'd3; // load tag of victim, move to front
    localparam logic [2:0] OP_HIT    = 3'd4; // move hit slot to front
    localparam logic [2:0] OP_FLAGS  = 3'd5;
    localparam logic [2:0] OP_INVAL  = 3'd6;
    localparam logic [2:0] OP_CLRMOD = 3'd7; // clear modified of slot at current rank

    // output item selection
    localparam logic [2:0] EM_WR0  = 3'd0;
    localparam logic [2:0] EM_WR1  = 3'd1;
    localparam logic [2:0] EM_READ = 3'd2;
    localparam logic [2:0] EM_DONE = 3'd3;

    typedef struct packed {
        logic [2:0] op;
        logic       emit;
        logic [2:0] em;
        logic       pick_victim; // select victim as working slot
        logic       rank_rst;    // restart rank walk
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       rank_end;  // rank walk at last rank
        logic       hit;       // current rank slot matches
        logic       mod;       // working slot modified
        logic       fat;       // working slot fat
        logic       cur_mod;   // slot at current rank modified
        logic       cur_fat;
    } t_sts;
endpackage

// ===== hw/rtl/lsbc_ctrl.sv =====
`timescale 1ns / 1ps
module lsbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_free,
    input  lsbc_pkg::t_sts  i_sts,
    output lsbc_pkg::t_cmd  o_cmd
);
    import lsbc_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_VWR0  = 4'd3;
    localparam logic [3:0] S_VWR1  = 4'd4;
    localparam logic [3:0] S_READ  = 4'd5;
    localparam logic [3:0] S_DONE  = 4'd6;
    localparam logic [3:0] S_FSCAN = 4'd7;
    localparam logic [3:0] S_FWR1  = 4'd8;

    logic [3:0] r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    o_cmd.rank_rst = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req)
                    REQ_OBTAIN: n_state = S_SCAN;
                    REQ_FLUSH:  n_state = S_FSCAN;
                    REQ_FLAGS: begin
                        o_cmd.op = OP_FLAGS;
                        n_state = S_DONE;
                    end
                    default: begin
                        o_cmd.op = OP_INVAL;
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.op = OP_SCAN;
                if (i_sts.hit) begin
                    o_cmd.op = OP_HIT;
                    n_state = S_DONE;
                end else if (i_sts.rank_end) begin
                    o_cmd.pick_victim = 1'b1;
                    n_state = S_VWR0;
                end
            end
            S_VWR0: begin
                if (!i_sts.mod) n_state = S_READ;
                else if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.em = EM_WR0;
                    n_state = i_sts.fat ? S_VWR1 : S_READ;
                end
            end
            S_VWR1: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.em = EM_WR1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.em = EM_READ;
                    o_cmd.op = OP_FILL;
                    n_state = S_DONE;
                end
            end
            S_FSCAN: begin
                o_cmd.pick_victim = 1'b0;
                if (i_sts.cur_mod) begin
                    if (i_out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.em = EM_WR0;
                        o_cmd.op = OP_CLRMOD;
                        if (i_sts.cur_fat) n_state = S_FWR1;
                        else if (i_sts.rank_end) n_state = S_DONE;
                        else o_cmd.op = OP_CLRMOD;
                    end
                end else if (i_sts.rank_end) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SCAN;
                end
            end
            S_FWR1: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.em = EM_WR1;
                    if (i_sts.rank_end) n_state = S_DONE;
                    else begin
                        o_cmd.op = OP_SCAN;
                        n_state = S_FSCAN;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.em = EM_DONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/lsbc_dp.sv =====
`timescale 1ns / 1ps
module lsbc_dp #(
    parameter int NUM_SLOTS   = lsbc_pkg::NUM_SLOTS_DEF,
    parameter int SECTOR_BITS = lsbc_pkg::SECTOR_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lsbc_pkg::t_cmd             i_cmd,
    output lsbc_pkg::t_sts             o_sts,
    input  logic [1:0]                 i_req,
    input  logic [lsbc_pkg::SECT_W-1:0] i_sector,
    input  logic [lsbc_pkg::SLOT_W-1:0] i_slot,
    input  logic                       i_set_mod,
    input  logic                       i_set_fat,
    input  logic                       i_set_rdy,
    input  logic [lsbc_pkg::SECT_W-1:0] i_fat_off,
    output logic [1:0]                 o_kind,
    output logic [lsbc_pkg::SECT_W-1:0] o_sect,
    output logic [lsbc_pkg::SLOT_W-1:0] o_bslot,
    output logic                       o_hit,
    output logic                       o_last
);
    import lsbc_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IW:0] LAST_RANK = (IW+1)'(NUM_SLOTS - 1);

    logic [NUM_SLOTS-1:0] r_valid, r_mod, r_fat, r_rdy;
    logic [SECTOR_BITS-1:0] r_tag [NUM_SLOTS];
    logic [IW-1:0] r_rank [NUM_SLOTS];

    logic [1:0] r_req;
    logic [SECTOR_BITS-1:0] r_sect;
    logic [SLOT_W-1:0] r_slot;
    logic r_smod, r_sfat, r_srdy;
    logic [IW:0] r_pos;        // rank walk position
    logic [IW-1:0] r_wslot;    // working slot
    logic r_have_rdy, r_hit;
    logic [IW-1:0] r_rdy_slot;

    logic [IW-1:0] cur, vict, tgt;
    logic cur_hit;

    // slot holding the current rank
    always_comb begin
        cur = '0;
        for (int s = 0; s < NUM_SLOTS; s++)
            if ({1'b0, r_rank[s]} == r_pos) cur = IW'(s);
    end

    assign cur_hit = r_valid[cur] && (r_tag[cur] == r_sect);
    assign vict = (r_have_rdy || r_rdy[cur]) ? (r_rdy[cur] ? cur : r_rdy_slot) : cur;
    assign tgt = (i_cmd.op == OP_HIT) ? cur : r_wslot;

    assign o_sts.req      = r_req;
    assign o_sts.rank_end = (r_pos == LAST_RANK);
    assign o_sts.hit      = cur_hit;
    assign o_sts.mod      = r_mod[r_wslot];
    assign o_sts.fat      = r_fat[r_wslot];
    assign o_sts.cur_mod  = r_mod[cur];
    assign o_sts.cur_fat  = r_fat[cur];

    // request latch and walk control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_have_rdy <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            if (i_cmd.rank_rst) begin
                r_pos <= '0;
                r_have_rdy <= 1'b0;
                r_hit <= 1'b0;
            end else if (i_cmd.op == OP_SCAN || (i_cmd.op == OP_CLRMOD && !o_sts.rank_end
                         && !r_fat[cur])) begin
                r_pos <= r_pos + 1'b1;
            end
            if (i_cmd.op == OP_SCAN && r_req == REQ_OBTAIN && r_rdy[cur]) begin
                r_have_rdy <= 1'b1;
            end
            if (i_cmd.op == OP_HIT) r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_req  <= i_req;
            r_sect <= SECTOR_BITS'(i_sector);
            r_slot <= i_slot;
            r_smod <= i_set_mod;
            r_sfat <= i_set_fat;
            r_srdy <= i_set_rdy;
        end
        if (i_cmd.op == OP_SCAN && r_req == REQ_OBTAIN && r_rdy[cur]) r_rdy_slot <= cur;
        if (i_cmd.pick_victim) r_wslot <= vict;
        if (i_cmd.op == OP_HIT) r_wslot <= cur;
        if (i_cmd.em == EM_WR0 && i_cmd.emit && r_req == REQ_FLUSH) r_wslot <= cur;
        if (i_cmd.op == OP_FILL) r_tag[r_wslot] <= r_sect;
    end

    // flags and recency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0; r_mod <= '0; r_fat <= '0; r_rdy <= '0;
            for (int s = 0; s < NUM_SLOTS; s++) r_rank[s] <= IW'(s);
        end else begin
            case (i_cmd.op)
                OP_FLAGS: begin
                    if ({1'b0, r_slot} < (SLOT_W+1)'(NUM_SLOTS) && r_valid[IW'(r_slot)]) begin
                        if (r_smod) r_mod[IW'(r_slot)] <= 1'b1;
                        if (r_sfat) r_fat[IW'(r_slot)] <= 1'b1;
                        if (r_srdy) r_rdy[IW'(r_slot)] <= 1'b1;
                    end
                end
                OP_INVAL: begin
                    r_valid <= '0; r_mod <= '0; r_fat <= '0; r_rdy <= '0;
                end
                OP_CLRMOD: r_mod[cur] <= 1'b0;
                OP_HIT, OP_FILL: begin
                    if (i_cmd.op == OP_FILL) begin
                        r_valid[tgt] <= 1'b1;
                        r_mod[tgt] <= 1'b0;
                        r_fat[tgt] <= 1'b0;
                    end
                    r_rdy[tgt] <= 1'b0;
                    for (int s = 0; s < NUM_SLOTS; s++)
                        if (r_rank[s] < r_rank[tgt]) r_rank[s] <= r_rank[s] + 1'b1;
                    r_rank[tgt] <= '0;
                end
                default: ;
            endcase
            if (i_cmd.em == EM_WR0 && i_cmd.emit && r_req == REQ_OBTAIN)
                r_mod[r_wslot] <= 1'b0;
        end
    end

    // result item fields
    logic [SECTOR_BITS-1:0] ws_tag, fs_tag;
    logic [IW-1:0] es;
    assign es = (r_req == REQ_FLUSH) ? ((i_cmd.em == EM_WR0) ? cur : r_wslot) : r_wslot;
    assign ws_tag = r_tag[es];
    assign fs_tag = ws_tag + SECTOR_BITS'(i_fat_off);
    always_comb begin
        o_kind = KIND_DONE; o_sect = '0; o_bslot = '0; o_hit = 1'b0; o_last = 1'b0;
        case (i_cmd.em)
            EM_WR0: begin
                o_kind = KIND_WRITE; o_sect = SECT_W'(ws_tag); o_bslot = SLOT_W'(es);
            end
            EM_WR1: begin
                o_kind = KIND_WRITE; o_sect = SECT_W'(fs_tag); o_bslot = SLOT_W'(es);
            end
            EM_READ: begin
                o_kind = KIND_READ; o_sect = SECT_W'(r_sect); o_bslot = SLOT_W'(r_wslot);
            end
            default: begin
                o_last = 1'b1;
                if (r_req == REQ_OBTAIN) begin
                    o_sect = SECT_W'(r_sect); o_bslot = SLOT_W'(r_wslot); o_hit = r_hit;
                end else if (r_req == REQ_FLAGS) o_bslot = r_slot;
            end
        endcase
    end
endmodule

// ===== hw/rtl/lru_sector_buffer_cache_top.sv =====
`timescale 1ns / 1ps
// channel | dir | fields (lowest bit first)
// s_axis  | in  | tuser: req_type; tdata: sector, slot, set_modified, set_fat, set_ready
// m_axis  | out | tuser: result_kind; tdata: disk_sector, buffer_slot, hit; tlast: last
// apb     | in  | fat_copy_offset at address 0
// one request at a time; set-flags and invalidate end with a done item
// an obtain miss writes back a modified victim and any fat copy before the read;
// a flush writes back every modified slot and any fat copy
// synchronous active-low reset clears flags and sets ranks to slot index.
// a full output register stalls the controller until the item is taken.
module lru_sector_buffer_cache_top #(
    parameter int NUM_SLOTS   = lsbc_pkg::NUM_SLOTS_DEF,
    parameter int SECTOR_BITS = lsbc_pkg::SECTOR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sector, slot, set_modified, set_fat, set_ready
    input  logic [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // disk_sector, buffer_slot, hit
    output logic [1:0]  m_axis_tuser,  // result_kind
    output logic        m_axis_tlast,  // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsbc_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [SECT_W-1:0] r_off;
    logic [1:0] kind;
    logic [SECT_W-1:0] sect;
    logic [SLOT_W-1:0] bslot;
    logic hitb, lastb, out_free;

    // config register
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_off} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_off <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) r_off <= pwdata[15:0];
    end

    assign out_free = !m_axis_tvalid || m_axis_tready;

    lsbc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_out_free(out_free), .i_sts(sts), .o_cmd(cmd)
    );

    lsbc_dp #(.NUM_SLOTS(NUM_SLOTS), .SECTOR_BITS(SECTOR_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_req(s_axis_tuser), .i_sector(s_axis_tdata[15:0]),
        .i_slot(s_axis_tdata[18:16]), .i_set_mod(s_axis_tdata[19]),
        .i_set_fat(s_axis_tdata[20]), .i_set_rdy(s_axis_tdata[21]),
        .i_fat_off(r_off), .o_kind(kind), .o_sect(sect), .o_bslot(bslot),
        .o_hit(hitb), .o_last(lastb)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) m_axis_tvalid <= 1'b0;
        else if (cmd.emit) m_axis_tvalid <= 1'b1;
        else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        if (cmd.emit) begin
            m_axis_tdata <= {4'b0, hitb, bslot, sect};
            m_axis_tuser <= kind;
            m_axis_tlast <= lastb;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> out_free) else $error("emit into full output");
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item taken while busy");
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import lsbc_pkg::*;

    localparam int NSLOT = 8;
    localparam int LIMIT_CYCLES = 400000;

    // result item as seen on the master side
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] sect;
        logic [2:0]  slot;
        logic        hit;
        logic        last;
    } t_res;

    // tracks cache state and queues the disk/done items it predicts
    class cache_scoreboard;
        logic        valid [NSLOT];
        logic        modif [NSLOT];
        logic        fat   [NSLOT];
        logic        rdy   [NSLOT];
        logic [15:0] tag   [NSLOT];
        int          rank  [NSLOT];
        logic [15:0] fat_ofs;
        t_res        pending[$];
        int          errors;
        int          n_res;
        int          n_hits;

        function new();
            fat_ofs = 0;
            errors = 0;
            n_res = 0;
            n_hits = 0;
            for (int s = 0; s < NSLOT; s++) begin
                valid[s] = 0; modif[s] = 0; fat[s] = 0; rdy[s] = 0;
                tag[s] = 0; rank[s] = s;
            end
        endfunction

        function void push(logic [1:0] k, logic [15:0] sc, int s, logic h, logic l);
            t_res r;
            r.kind = k; r.sect = sc; r.slot = s[2:0]; r.hit = h; r.last = l;
            pending.push_back(r);
        endfunction

        function void promote(int s);
            int r;
            r = rank[s];
            for (int i = 0; i < NSLOT; i++)
                if (rank[i] < r) rank[i]++;
            rank[s] = 0;
        endfunction

        function void write_back(int s);
            push(KIND_WRITE, tag[s], s, 0, 0);
            modif[s] = 0;
            if (fat[s]) push(KIND_WRITE, tag[s] + fat_ofs, s, 0, 0);
        endfunction

        // note an accepted request and predict its items
        function void note_request(logic [1:0] req, logic [23:0] d);
            int          order [NSLOT];
            logic [15:0] sc;
            int          sl, v, rs;
            bit          have_rdy;
            sc = d[15:0];
            sl = int'(d[18:16]);
            for (int s = 0; s < NSLOT; s++) order[rank[s]] = s;
            if (req == REQ_OBTAIN) begin
                have_rdy = 0;
                rs = 0;
                for (int i = 0; i < NSLOT; i++) begin
                    if (valid[order[i]] && tag[order[i]] == sc) begin
                        promote(order[i]);
                        rdy[order[i]] = 0;
                        push(KIND_DONE, sc, order[i], 1, 1);
                        return;
                    end
                    if (rdy[order[i]]) begin
                        have_rdy = 1;
                        rs = order[i];
                    end
                end
                v = have_rdy ? rs : order[NSLOT-1];
                rdy[v] = 0;
                if (modif[v]) write_back(v);
                push(KIND_READ, sc, v, 0, 0);
                valid[v] = 1; modif[v] = 0; fat[v] = 0; tag[v] = sc;
                promote(v);
                push(KIND_DONE, sc, v, 0, 1);
            end else if (req == REQ_FLAGS) begin
                if (valid[sl]) begin
                    if (d[19]) modif[sl] = 1;
                    if (d[20]) fat[sl] = 1;
                    if (d[21]) rdy[sl] = 1;
                end
                push(KIND_DONE, 0, sl, 0, 1);
            end else if (req == REQ_FLUSH) begin
                for (int i = 0; i < NSLOT; i++)
                    if (modif[order[i]]) write_back(order[i]);
                push(KIND_DONE, 0, 0, 0, 1);
            end else begin
                for (int s = 0; s < NSLOT; s++) begin
                    valid[s] = 0; modif[s] = 0; fat[s] = 0; rdy[s] = 0;
                end
                push(KIND_DONE, 0, 0, 0, 1);
            end
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch on item %0d: %s got %0h want %0h", n_res, what, got, want);
            errors++;
        endtask

        // compare one accepted result item with the oldest expectation
        task check_result(logic [1:0] k, logic [23:0] d, logic l);
            t_res w;
            if (pending.size() == 0) begin
                report("unexpected item", d, 0);
            end else begin
                w = pending.pop_front();
                if (k != w.kind) report("kind", k, w.kind);
                if (d[15:0] != w.sect) report("sector", d[15:0], w.sect);
                if (d[18:16] != w.slot) report("slot", d[18:16], w.slot);
                if (d[19] != w.hit) report("hit", d[19], w.hit);
                if (d[23:20] != 0) report("pad", d[23:20], 0);
                if (l != w.last) report("last", l, w.last);
                if (w.kind == KIND_DONE && w.hit) n_hits++;
            end
            n_res++;
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    cache_scoreboard sb = new();
    int cycles = 0;
    bit stim_done = 0;
    logic [15:0] hot [8];

    lru_sector_buffer_cache_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout with %0d items pending", sb.pending.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver with random stalls per item
    initial begin : sink
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = $urandom_range(0, 8);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_axis_tready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_axis_tready <= 1;
            @(posedge i_clk iff m_axis_tvalid);
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_req(logic [1:0] rq, logic [15:0] sc, logic [2:0] sl,
                            logic m, logic f, logic r, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 8) : 0;
        if (w > 0) begin
            s_axis_tvalid <= 0;
            repeat (w) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= rq;
        s_axis_tdata <= {2'b0, r, f, m, sl, sc};
        @(posedge i_clk iff s_axis_tready);
        sb.note_request(rq, {2'b0, r, f, m, sl, sc});
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_offset(logic [15:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0;
        pwdata <= {16'h0, v};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk iff pready);
        sb.fat_ofs = v;
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // mostly obtains on a small working set so hits, victims and write-backs occur
    task automatic random_phase(int n);
        int p;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 55)
                send_req(REQ_OBTAIN, ($urandom_range(0, 9) == 0) ? 16'($urandom)
                         : hot[$urandom_range(0, 7) % 8] ^ 16'($urandom_range(0, 3)),
                         3'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1);
            else if (p < 85)
                send_req(REQ_FLAGS, 16'($urandom), 3'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom), 1);
            else if (p < 95)
                send_req(REQ_FLUSH, 16'($urandom), 3'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom), 1);
            else
                send_req(REQ_INVAL, 16'($urandom), 3'($urandom),
                         1'($urandom), 1'($urandom), 1'($urandom), 1);
        end
    endtask

    initial begin : stim
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        write_offset(16'hFFFF);
        // directed: fill, hit, flags on invalid slot, fat wraparound, flush, invalidate
        send_req(REQ_FLAGS, 16'h0, 3'd7, 1, 1, 1, 0);
        send_req(REQ_OBTAIN, 16'h0000, 3'd0, 0, 0, 0, 0);
        send_req(REQ_OBTAIN, 16'hFFFF, 3'd7, 1, 1, 1, 0);
        send_req(REQ_OBTAIN, 16'h0000, 3'd0, 0, 0, 0, 0);
        for (int s = 0; s < 8; s++)
            send_req(REQ_FLAGS, 16'hFFFF, 3'(s), 1, 1, 0, 0);
        send_req(REQ_FLUSH, 16'h0, 3'd0, 0, 0, 0, 0);
        send_req(REQ_FLAGS, 16'h0, 3'd0, 1, 1, 1, 0);
        send_req(REQ_FLAGS, 16'h0, 3'd1, 0, 0, 1, 0);
        send_req(REQ_OBTAIN, 16'h1234, 3'd0, 0, 0, 0, 0);
        send_req(REQ_OBTAIN, 16'h5678, 3'd0, 0, 0, 0, 0);
        for (int s = 0; s < 6; s++)
            send_req(REQ_OBTAIN, 16'h0100 + 16'(s), 3'd0, 0, 0, 0, 0);
        send_req(REQ_FLAGS, 16'h0, 3'd2, 1, 0, 0, 0);
        send_req(REQ_OBTAIN, 16'hABCD, 3'd0, 0, 0, 0, 0);
        send_req(REQ_INVAL, 16'hFFFF, 3'd7, 1, 1, 1, 0);
        send_req(REQ_OBTAIN, 16'h0000, 3'd0, 0, 0, 0, 0);
        drain();
        // random phases across several offsets
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_offset(16'h0000);
                1: write_offset(16'h8000);
                2: write_offset(16'($urandom));
                default: write_offset(16'hFFFF);
            endcase
            for (int h = 0; h < 8; h++) hot[h] = 16'($urandom);
            random_phase(63);
            drain();
        end
        stim_done = 1;
    end

    initial begin : finish_up
        wait (stim_done);
        $display("covered %0d result items, %0d hits, over 4 offset settings",
                 sb.n_res, sb.n_hits);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d left pending", sb.errors, sb.pending.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
